>>> rtl/core/chtab_pkg.sv
package chtab_pkg;

	localparam int MAX_BUCKETS  = 64;
	localparam int POOL_NODES   = 256;
	localparam int PAYLOAD_BITS = 32;
	localparam int KEY_BITS     = 31;
	localparam int BCNT_BITS    = 7;

	localparam int NODE_ADDR_W = $clog2(POOL_NODES);
	localparam int NODE_W      = $clog2(POOL_NODES + 1);
	localparam int BKT_ADDR_W  = $clog2(MAX_BUCKETS);

	localparam logic [NODE_W-1:0] NIL_NODE = NODE_W'(POOL_NODES);

	localparam logic [1:0] CMD_SEARCH = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_ABSENT = 2'd1;
	localparam logic [1:0] STS_DUP    = 2'd2;
	localparam logic [1:0] STS_FULL   = 2'd3;

	// key is padded to 32 bits and divided 4 bits per cycle
	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = 32 / DIV_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_HEAD,
		S_WALK,
		S_CMP,
		S_ACT,
		S_FREE,
		S_REM2,
		S_DONE
	} state_t;

endpackage

>>> rtl/core/chained_hash_table.sv
// Hash table with separate chaining over a 256-node pool, 64 buckets max.
// A clear goes straight to the result; other requests divide the key, read the
// bucket head, then walk the chain comparing each node, with an extra step when
// the walk runs off the chain end and one more for an add or remove that changes
// the table. One request in flight; the next is taken in the cycle after the result loads.
// Reset: all buckets empty, free list holds every node in order, count 13.
// Reset and clear act at once via head valid bits and a pool fill mark.
module chained_hash_table (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [chtab_pkg::BCNT_BITS-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           command,
	input  logic [chtab_pkg::KEY_BITS-1:0]       key,
	input  logic [chtab_pkg::PAYLOAD_BITS-1:0]   payload,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic [chtab_pkg::PAYLOAD_BITS-1:0]   found_payload
);
	import chtab_pkg::*;

	localparam int DATA_W = KEY_BITS + PAYLOAD_BITS;

	state_t state_q, state_d;

	// configuration
	logic [BCNT_BITS-1:0] bcnt_q;
	logic [BCNT_BITS-1:0] div_eff;

	// request
	logic [1:0]              cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// remainder unit
	logic [31:0]          dvd_q;
	logic [BCNT_BITS-1:0] div_q;
	logic [BCNT_BITS-1:0] rem_q;
	logic [BCNT_BITS-1:0] rem_nx;
	logic [$clog2(DIV_STEPS)-1:0] dcnt_q;

	// walk
	logic [NODE_W-1:0] head_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] prev_q;
	logic [NODE_W-1:0] nlink_q;
	logic [NODE_W-1:0] steps_q;
	logic              hit_q;
	logic [PAYLOAD_BITS-1:0] hit_pay_q;
	logic [NODE_W-1:0] free_q;

	// answer of the request in flight, then the result register
	logic [1:0]              ans_sts_q;
	logic [PAYLOAD_BITS-1:0] ans_pay_q;
	logic [1:0]              res_sts_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic                    res_vld_q;

	// a bucket not marked valid reads as empty; nodes at or above the fill
	// mark were never taken and link to the next node in order
	logic [MAX_BUCKETS-1:0] head_vld_q;
	logic [NODE_W-1:0]      fill_q;

	// RAM ports
	logic                    hd_we, hd_re;
	logic [BKT_ADDR_W-1:0]   hd_addr;
	logic [NODE_W-1:0]       hd_wdata, hd_rdata;
	logic                    dt_we, dt_re;
	logic [NODE_ADDR_W-1:0]  dt_waddr, dt_raddr;
	logic [DATA_W-1:0]       dt_wdata, dt_rdata;
	logic                    lk_we, lk_re;
	logic [NODE_ADDR_W-1:0]  lk_waddr, lk_raddr;
	logic [NODE_W-1:0]       lk_wdata, lk_rdata;

	logic [NODE_W-1:0] cur_link;
	logic [NODE_W-1:0] free_link;
	logic [NODE_W-1:0] head_rd;

	logic in_acc;
	logic res_load;

	chtab_ram #(.WIDTH(NODE_W), .DEPTH(MAX_BUCKETS)) u_heads (
		.clk(clk), .wr_en(hd_we), .wr_addr(hd_addr), .wr_data(hd_wdata),
		.rd_en(hd_re), .rd_addr(hd_addr), .rd_data(hd_rdata)
	);

	chtab_ram #(.WIDTH(DATA_W), .DEPTH(POOL_NODES)) u_data (
		.clk(clk), .wr_en(dt_we), .wr_addr(dt_waddr), .wr_data(dt_wdata),
		.rd_en(dt_re), .rd_addr(dt_raddr), .rd_data(dt_rdata)
	);

	chtab_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_links (
		.clk(clk), .wr_en(lk_we), .wr_addr(lk_waddr), .wr_data(lk_wdata),
		.rd_en(lk_re), .rd_addr(lk_raddr), .rd_data(lk_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = res_vld_q;
	assign status        = res_sts_q;
	assign found_payload = res_pay_q;

	// clamp the modulus into 1..MAX_BUCKETS
	always_comb begin
		if (bcnt_q == '0) begin
			div_eff = BCNT_BITS'(1);
		end else if (bcnt_q > BCNT_BITS'(MAX_BUCKETS)) begin
			div_eff = BCNT_BITS'(MAX_BUCKETS);
		end else begin
			div_eff = bcnt_q;
		end
	end

	// four restoring steps per cycle; remainder stays below the divisor
	always_comb begin
		logic [BCNT_BITS:0] r;
		r = '0;
		rem_nx = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {rem_nx, dvd_q[31-i]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
			rem_nx = r[BCNT_BITS-1:0];
		end
	end

	// chain nodes were all taken from the pool, so their links are written;
	// the free head at the fill mark is a fresh node linking to the next one
	assign cur_link  = lk_rdata;
	assign free_link = (free_q == fill_q) ? free_q + NODE_W'(1) : lk_rdata;
	assign head_rd   = head_vld_q[rem_q[BKT_ADDR_W-1:0]] ? hd_rdata : NIL_NODE;

	// next state and RAM controls
	always_comb begin
		state_d  = state_q;
		hd_we    = 1'b0;
		hd_re    = 1'b0;
		hd_addr  = rem_q[BKT_ADDR_W-1:0];
		hd_wdata = free_q;
		dt_we    = 1'b0;
		dt_re    = 1'b0;
		dt_waddr = free_q[NODE_ADDR_W-1:0];
		dt_raddr = cur_q[NODE_ADDR_W-1:0];
		dt_wdata = {key_q, pay_q};
		lk_we    = 1'b0;
		lk_re    = 1'b0;
		lk_waddr = free_q[NODE_ADDR_W-1:0];
		lk_raddr = cur_q[NODE_ADDR_W-1:0];
		lk_wdata = head_q;
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (command == CMD_CLEAR) ? S_DONE : S_DIV;
				end
			end
			S_DIV: begin
				if (dcnt_q == '1) begin
					hd_re   = 1'b1;
					hd_addr = rem_nx[BKT_ADDR_W-1:0];
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				if (cur_q[NODE_W-1] || steps_q == NIL_NODE) begin
					state_d = S_ACT;
				end else begin
					dt_re   = 1'b1;
					lk_re   = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				state_d = (dt_rdata[DATA_W-1 -: KEY_BITS] == key_q) ? S_ACT : S_WALK;
			end
			S_ACT: begin
				state_d = S_DONE;
				if (cmd_q == CMD_ADD && !hit_q && !free_q[NODE_W-1]) begin
					lk_re    = 1'b1;
					lk_raddr = free_q[NODE_ADDR_W-1:0];
					state_d  = S_FREE;
				end else if (cmd_q == CMD_REMOVE && hit_q) begin
					// unlink: predecessor or bucket head takes the successor
					if (prev_q[NODE_W-1]) begin
						hd_we    = 1'b1;
						hd_wdata = nlink_q;
					end else begin
						lk_we    = 1'b1;
						lk_waddr = prev_q[NODE_ADDR_W-1:0];
						lk_wdata = nlink_q;
					end
					state_d = S_REM2;
				end
			end
			S_FREE: begin
				dt_we   = 1'b1;
				lk_we   = 1'b1;
				hd_we   = 1'b1;
				state_d = S_DONE;
			end
			S_REM2: begin
				lk_we    = 1'b1;
				lk_waddr = cur_q[NODE_ADDR_W-1:0];
				lk_wdata = free_q;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!res_vld_q || out_ready) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q     <= BCNT_BITS'(13);
			head_vld_q <= '0;
			fill_q     <= '0;
			free_q     <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bcnt_q <= cfg_data;
			end
			if (in_acc && command == CMD_CLEAR) begin
				head_vld_q <= '0;
				fill_q     <= '0;
				free_q     <= '0;
			end
			if (hd_we) begin
				head_vld_q[hd_addr] <= 1'b1;
			end
			if (state_q == S_FREE) begin
				free_q <= free_link;
				if (free_q == fill_q) begin
					fill_q <= fill_q + NODE_W'(1);
				end
			end
			if (state_q == S_REM2) begin
				free_q <= cur_q;
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= command;
			key_q  <= key;
			pay_q  <= payload;
			dvd_q  <= {1'b0, key};
			div_q  <= div_eff;
			rem_q  <= '0;
			dcnt_q <= '0;
			hit_q  <= 1'b0;
			hit_pay_q <= '0;
		end
		if (state_q == S_DIV) begin
			dvd_q  <= dvd_q << DIV_BITS;
			rem_q  <= rem_nx;
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (state_q == S_HEAD) begin
			head_q  <= head_rd;
			cur_q   <= head_rd;
			prev_q  <= NIL_NODE;
			steps_q <= '0;
		end
		if (state_q == S_CMP) begin
			if (dt_rdata[DATA_W-1 -: KEY_BITS] == key_q) begin
				hit_q     <= 1'b1;
				hit_pay_q <= dt_rdata[PAYLOAD_BITS-1:0];
				nlink_q   <= cur_link;
			end else begin
				prev_q  <= cur_q;
				cur_q   <= cur_link;
				steps_q <= steps_q + 1'b1;
			end
		end
		if (state_q == S_ACT) begin
			ans_pay_q <= '0;
			unique case (cmd_q)
				CMD_SEARCH: begin
					ans_sts_q <= hit_q ? STS_OK : STS_ABSENT;
					ans_pay_q <= hit_q ? hit_pay_q : '0;
				end
				CMD_ADD: begin
					if (hit_q) begin
						ans_sts_q <= STS_DUP;
					end else if (free_q[NODE_W-1]) begin
						ans_sts_q <= STS_FULL;
					end else begin
						ans_sts_q <= STS_OK;
					end
				end
				default: ans_sts_q <= hit_q ? STS_OK : STS_ABSENT;
			endcase
		end
		if (in_acc && command == CMD_CLEAR) begin
			ans_sts_q <= STS_OK;
			ans_pay_q <= '0;
		end
		// hold the waiting result until the answer is handed over
		if (res_load) begin
			res_sts_q <= ans_sts_q;
			res_pay_q <= ans_pay_q;
		end
	end

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEAD |-> rem_q < div_q)
		else $error("bucket index not below bucket count");

	a_walk_not_nil: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> !cur_q[NODE_W-1])
		else $error("chain walk read past null");

	a_free_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NIL_NODE)
		else $error("free list head out of range");

	a_clear_resets_pool: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_CLEAR |=> free_q == '0 && head_vld_q == '0)
		else $error("clear did not rebuild the pool");

endmodule

>>> rtl/core/chtab_ram.sv
module chtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
